@@ sv/mf3_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mf3_pkg
// Shared types, constants and compare helpers for the 3x3 median filter.
// -----------------------------------------------------------------------------
package mf3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIXEL_BITS = 8;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int DIM_BITS   = 11;
  localparam int ADDR_BITS  = 3;
  localparam int DATA_BITS  = 32;
  localparam int WIN_SIZE   = 3;
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS   = PTR_BITS + 1;

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [COL_BITS-1:0]   col_t;
  typedef logic [DIM_BITS-1:0]   dim_t;
  typedef logic [PTR_BITS-1:0]   ptr_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;

  typedef logic [WIN_SIZE-1:0][WIN_SIZE-1:0][PIXEL_BITS-1:0] win_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic emit;
    logic border;
    logic last;
  } tag_t;

  typedef struct packed {
    logic adv;
    col_t col;
    pix_t pix;
    tag_t tag;
  } step_t;

  typedef struct packed {
    logic valid;
    logic border;
    logic last;
  } stage_t;

  typedef struct packed {
    logic valid;
    pix_t pix;
    logic last;
  } res_t;

  typedef struct packed {
    pix_t lo;
    pix_t md;
    pix_t hi;
  } sort3_t;

  function automatic pix_t pmin(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t pmax(pix_t a, pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic sort3_t sort3(pix_t a, pix_t b, pix_t c);
    pix_t   x;
    pix_t   y;
    pix_t   t;
    sort3_t s;
    x    = pmin(a, b);
    y    = pmax(a, b);
    s.lo = pmin(x, c);
    t    = pmax(x, c);
    s.md = pmin(y, t);
    s.hi = pmax(y, t);
    return s;
  endfunction

  function automatic dim_t clamp_dim(dim_t raw, dim_t limit);
    dim_t v;
    if (raw == '0) begin
      v = DIM_BITS'(1);
    end else if (raw > limit) begin
      v = limit;
    end else begin
      v = raw;
    end
    return v;
  endfunction

endpackage

@@ sv/mf3_regs.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mf3_regs
// Register file for frame width and height behind the bus port.
// -----------------------------------------------------------------------------
module mf3_regs import mf3_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output dim_t                 width,
  output dim_t                 height,
  output logic                 cfg_wr
);

  dim_t     frame_width;
  dim_t     frame_height;
  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[2]);
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_BITS'(RESET_WIDTH);
      frame_height <= DIM_BITS'(RESET_HEIGHT);
    end else if (cfg_wr) begin
      unique case (idx)
        REG_WIDTH:  frame_width  <= pwdata[DIM_BITS-1:0];
        REG_HEIGHT: frame_height <= pwdata[DIM_BITS-1:0];
        default:    frame_width  <= frame_width;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WIDTH:  prdata = DATA_BITS'(frame_width);
      REG_HEIGHT: prdata = DATA_BITS'(frame_height);
      default:    prdata = '0;
    endcase
  end

  assign width  = clamp_dim(frame_width, DIM_BITS'(MAX_WIDTH));
  assign height = clamp_dim(frame_height, DIM_BITS'(MAX_HEIGHT));

endmodule

@@ sv/mf3_ctrl.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mf3_ctrl
// Input and output position counters; decides which transfers advance the
// window and which release a result, and marks border and last pixels.
// -----------------------------------------------------------------------------
module mf3_ctrl import mf3_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  input  logic  item_stall,
  input  logic  opcode,
  input  pix_t  pixel_in,
  input  dim_t  width,
  input  dim_t  height,
  input  logic  cfg_wr,
  output step_t step
);

  col_t col, col_next;
  dim_t in_row, in_row_next;
  dim_t lead, lead_next;
  col_t out_col, out_col_next;
  dim_t out_row, out_row_next;

  logic pix_phase;
  logic adv;
  logic col_wrap;
  logic emit;
  logic out_col_wrap;
  logic out_row_end;
  logic narrow;
  logic border;
  logic last;

  assign pix_phase    = in_row < height;
  assign adv          = item_valid & ~item_stall & ~(pix_phase & (opcode == OP_DRAIN));
  assign col_wrap     = DIM_BITS'(col) == (width - DIM_BITS'(1));
  assign emit         = lead == (width + DIM_BITS'(1));
  assign out_col_wrap = DIM_BITS'(out_col) == (width - DIM_BITS'(1));
  assign out_row_end  = out_row == (height - DIM_BITS'(1));
  assign narrow       = (width < DIM_BITS'(WIN_SIZE)) | (height < DIM_BITS'(WIN_SIZE));
  assign border       = narrow | (out_row == '0) | (out_col == '0) | out_row_end | out_col_wrap;
  assign last         = out_row_end & out_col_wrap;

  always_comb begin
    col_next     = col;
    in_row_next  = in_row;
    lead_next    = lead;
    out_col_next = out_col;
    out_row_next = out_row;
    if (cfg_wr) begin
      col_next     = '0;
      in_row_next  = '0;
      lead_next    = '0;
      out_col_next = '0;
      out_row_next = '0;
    end else if (adv) begin
      col_next = col_wrap ? '0 : col + COL_BITS'(1);
      if (pix_phase && col_wrap) begin
        in_row_next = in_row + DIM_BITS'(1);
      end
      if (!emit) begin
        lead_next = lead + DIM_BITS'(1);
      end else if (last) begin
        col_next     = '0;
        in_row_next  = '0;
        lead_next    = '0;
        out_col_next = '0;
        out_row_next = '0;
      end else begin
        out_col_next = out_col_wrap ? '0 : out_col + COL_BITS'(1);
        if (out_col_wrap) begin
          out_row_next = out_row + DIM_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      in_row  <= '0;
      lead    <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      col     <= col_next;
      in_row  <= in_row_next;
      lead    <= lead_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
    end
  end

  assign step.adv        = adv;
  assign step.col        = col;
  assign step.pix        = pixel_in;
  assign step.tag.emit   = emit;
  assign step.tag.border = border;
  assign step.tag.last   = last;

endmodule

@@ sv/mf3_window.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mf3_window
// Two line stores and the 3x3 window; the window center is the pixel whose
// result is released by the same transfer.
// -----------------------------------------------------------------------------
module mf3_window import mf3_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  step_t  step,
  output logic   s1_emit,
  output stage_t s2,
  output win_t   win
);

  pix_t store_a [MAX_WIDTH];
  pix_t store_b [MAX_WIDTH];
  pix_t rd_a;
  pix_t rd_b;

  logic s1_adv;
  col_t s1_col;
  pix_t s1_pix;
  tag_t s1_tag;

  always_ff @(posedge clk) begin
    if (step.adv) begin
      store_a[step.col] <= step.pix;
      rd_a              <= store_a[step.col];
    end
  end

  // row two above: refill with the value just read from the row above
  always_ff @(posedge clk) begin
    if (step.adv) begin
      rd_b <= store_b[step.col];
    end
    if (s1_adv) begin
      store_b[s1_col] <= rd_a;
    end
  end

  always_ff @(posedge clk) begin
    s1_col <= step.col;
    s1_pix <= step.pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_adv <= 1'b0;
      s1_tag <= '0;
    end else begin
      s1_adv <= step.adv;
      s1_tag <= step.tag;
    end
  end

  assign s1_emit = s1_adv & s1_tag.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
      s2  <= '0;
    end else begin
      s2.valid  <= s1_emit;
      s2.border <= s1_tag.border;
      s2.last   <= s1_tag.last;
      if (s1_adv) begin
        for (int r = 0; r < WIN_SIZE; r++) begin
          win[r][0] <= win[r][1];
          win[r][1] <= win[r][2];
        end
        win[0][2] <= rd_b;
        win[1][2] <= rd_a;
        win[2][2] <= s1_pix;
      end
    end
  end

endmodule

@@ sv/mf3_median.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mf3_median
// Median of nine in two steps: sort each column, then take the median of the
// largest low, middle median and smallest high. Border pixels pass through.
// -----------------------------------------------------------------------------
module mf3_median import mf3_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  stage_t s2,
  input  win_t   win,
  output logic   s3_valid,
  output res_t   res
);

  sort3_t cols [WIN_SIZE];
  pix_t   center;
  logic   s3_border;
  logic   s3_last;
  sort3_t lo_s;
  sort3_t md_s;
  sort3_t hi_s;
  sort3_t fin_s;

  always_ff @(posedge clk) begin
    for (int c = 0; c < WIN_SIZE; c++) begin
      cols[c] <= sort3(win[0][c], win[1][c], win[2][c]);
    end
    center    <= win[1][1];
    s3_border <= s2.border;
    s3_last   <= s2.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2.valid;
    end
  end

  assign lo_s  = sort3(cols[0].lo, cols[1].lo, cols[2].lo);
  assign md_s  = sort3(cols[0].md, cols[1].md, cols[2].md);
  assign hi_s  = sort3(cols[0].hi, cols[1].hi, cols[2].hi);
  assign fin_s = sort3(lo_s.hi, md_s.md, hi_s.lo);

  assign res.valid = s3_valid;
  assign res.pix   = s3_border ? center : fin_s.md;
  assign res.last  = s3_last;

endmodule

@@ sv/mf3_out_fifo.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mf3_out_fifo
// Result queue between the filter pipeline and the output channel.
// -----------------------------------------------------------------------------
module mf3_out_fifo import mf3_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  res_t res,
  input  logic result_stall,
  output logic result_valid,
  output pix_t pixel_out,
  output logic frame_last,
  output cnt_t count
);

  pix_t q_pix  [FIFO_DEPTH];
  logic q_last [FIFO_DEPTH];
  ptr_t wr_ptr;
  ptr_t rd_ptr;
  logic pop;

  assign result_valid = count != '0;
  assign pop          = result_valid & ~result_stall;
  assign pixel_out    = q_pix[rd_ptr];
  assign frame_last   = q_last[rd_ptr];

  always_ff @(posedge clk) begin
    if (res.valid) begin
      q_pix[wr_ptr]  <= res.pix;
      q_last[wr_ptr] <= res.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_BITS'(res.valid);
      rd_ptr <= rd_ptr + PTR_BITS'(pop);
      count  <= count + CNT_BITS'(res.valid) - CNT_BITS'(pop);
    end
  end

endmodule

@@ sv/median_filter_3x3.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// median_filter_3x3
// Streaming 3x3 median filter over one grey frame in raster order.
// Throughput: one transfer per clock; the input stalls only when the result
// queue plus the three pipeline stages hold eight results.
// A result passes the s1, s2 and s3 registers and the result queue on its way
// to the output. Reset clears counters and the window; registers go to 640x480.
// -----------------------------------------------------------------------------
module median_filter_3x3 import mf3_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 opcode,
  input  pix_t                 pixel_in,
  output logic                 result_valid,
  input  logic                 result_stall,
  output pix_t                 pixel_out,
  output logic                 frame_last
);

  dim_t   width;
  dim_t   height;
  logic   cfg_wr;
  step_t  step;
  logic   s1_emit;
  stage_t s2;
  win_t   win;
  logic   s3_valid;
  res_t   res;
  cnt_t   count;
  cnt_t   pending;

  mf3_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .width   (width),
    .height  (height),
    .cfg_wr  (cfg_wr)
  );

  mf3_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .opcode     (opcode),
    .pixel_in   (pixel_in),
    .width      (width),
    .height     (height),
    .cfg_wr     (cfg_wr),
    .step       (step)
  );

  mf3_window u_window (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .s1_emit (s1_emit),
    .s2      (s2),
    .win     (win)
  );

  mf3_median u_median (
    .clk      (clk),
    .rst      (rst),
    .s2       (s2),
    .win      (win),
    .s3_valid (s3_valid),
    .res      (res)
  );

  mf3_out_fifo u_out_fifo (
    .clk          (clk),
    .rst          (rst),
    .res          (res),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .pixel_out    (pixel_out),
    .frame_last   (frame_last),
    .count        (count)
  );

  // hold input while queued plus in-flight results could overrun the queue
  assign pending    = CNT_BITS'(s1_emit) + CNT_BITS'(s2.valid) + CNT_BITS'(s3_valid);
  assign item_stall = (count + pending) >= CNT_BITS'(FIFO_DEPTH);

endmodule

@@ tb/tb_median_filter_3x3.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_median_filter_3x3
// Self-checking bench for the streaming 3x3 median filter. A built-in
// pixel-stream model predicts every output pixel and end-of-frame flag from
// the accepted transfers, and a scoreboard compares results in order. Covers
// reset geometry, border and tiny frames, clamped sizes, early drains, excess
// pixels, truncated frames and long runs of random frames with and without
// random input gaps and output stalls.
// -----------------------------------------------------------------------------
module tb_median_filter_3x3;
  import mf3_pkg::*;

  localparam int HIST_LEN     = 2 * MAX_WIDTH + 3;
  localparam int RANDOM_ITEMS = 300;
  localparam int DRAIN_LIMIT  = 50000;
  localparam int TAIL_CYCLES  = 12;

  typedef struct packed {
    pix_t pix;
    logic last;
  } out_px_t;

  typedef enum int {
    MIX_UNIFORM,
    MIX_EXTREME,
    MIX_LEVELS,
    MIX_NARROW
  } pix_mix_t;

  logic                 clk;
  logic                 rst          = 1'b1;
  logic                 psel         = 1'b0;
  logic                 penable      = 1'b0;
  logic                 pwrite       = 1'b0;
  logic [ADDR_BITS-1:0] paddr        = '0;
  logic [DATA_BITS-1:0] pwdata       = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;
  logic                 item_valid   = 1'b0;
  logic                 item_stall;
  logic                 opcode       = OP_PIXEL;
  pix_t                 pixel_in     = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  pix_t                 pixel_out;
  logic                 frame_last;

  bit send_gaps_on   = 1'b1;
  bit recv_stalls_on = 1'b1;
  int mismatches     = 0;
  int items_fed      = 0;

  pix_t        hist_px [HIST_LEN];
  dim_t        cfg_width;
  dim_t        cfg_height;
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned drains_seen;
  int unsigned next_out;
  out_px_t     filtered_pixels_q[$];

  median_filter_3x3 dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .opcode       (opcode),
    .pixel_in     (pixel_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .pixel_out    (pixel_out),
    .frame_last   (frame_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Pixel-stream model
  // ---------------------------------------------------------------------------
  function automatic int unsigned usable_dim(dim_t raw, int unsigned top);
    if (raw == '0) begin
      return 1;
    end
    return (raw > top) ? top : int'(raw);
  endfunction

  function automatic void restart_counters();
    col_pos     = 0;
    row_pos     = 0;
    drains_seen = 0;
    next_out    = 0;
  endfunction

  function automatic pix_t window_median(int unsigned p, int unsigned w);
    pix_t v[9];
    pix_t t;
    int   k;
    int   j;
    int   dr;
    int   dc;
    k = 0;
    for (dr = 0; dr < 3; dr++) begin
      for (dc = 0; dc < 3; dc++) begin
        v[k] = hist_px[(p - w - 1 + dr * w + dc) % HIST_LEN];
        k++;
      end
    end
    for (k = 1; k < 9; k++) begin
      t = v[k];
      j = k - 1;
      while (j >= 0 && v[j] > t) begin
        v[j+1] = v[j];
        j--;
      end
      v[j+1] = t;
    end
    return v[4];
  endfunction

  function automatic void compute_filtered_pixel(op_t op, pix_t px);
    int unsigned w;
    int unsigned h;
    int unsigned total;
    int unsigned seen;
    int unsigned p;
    int unsigned r;
    int unsigned c;
    out_px_t     o;
    w     = usable_dim(cfg_width, MAX_WIDTH);
    h     = usable_dim(cfg_height, MAX_HEIGHT);
    total = w * h;
    seen  = row_pos * w + col_pos;
    if (seen < total) begin
      if (op != OP_PIXEL) begin
        return;
      end
      hist_px[seen % HIST_LEN] = px;
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      seen++;
    end else begin
      drains_seen++;
    end
    items_fed++;
    if (seen + drains_seen <= w + 1) begin
      return;
    end
    p = next_out;
    r = p / w;
    c = p % w;
    if (w < 3 || h < 3 || r == 0 || c == 0 || r == h - 1 || c == w - 1) begin
      o.pix = hist_px[p % HIST_LEN];
    end else begin
      o.pix = window_median(p, w);
    end
    o.last = (p >= total - 1);
    if (o.last) begin
      restart_counters();
    end else begin
      next_out++;
    end
    filtered_pixels_q.push_back(o);
  endfunction

  // ---------------------------------------------------------------------------
  // Result scoreboard
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_px_t want;
    if (!rst && result_valid && !result_stall) begin
      if (filtered_pixels_q.size() == 0) begin
        $display("%0t unexpected result: pixel_out %0d frame_last %0d",
                 $time, pixel_out, frame_last);
        mismatches++;
      end else begin
        want = filtered_pixels_q.pop_front();
        if (pixel_out !== want.pix) begin
          $display("%0t pixel_out mismatch: expected %0d actual %0d",
                   $time, want.pix, pixel_out);
          mismatches++;
        end
        if (frame_last !== want.last) begin
          $display("%0t frame_last mismatch: expected %0d actual %0d",
                   $time, want.last, frame_last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_stall <= recv_stalls_on && ($urandom_range(99) < 13);
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_item(input op_t op, input pix_t px);
    while (send_gaps_on && $urandom_range(99) < 13) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    opcode     <= op;
    pixel_in   <= px;
    @(posedge clk);
    while (item_stall) begin
      @(posedge clk);
    end
    compute_filtered_pixel(op, px);
  endtask

  task automatic wait_drained();
    int n;
    item_valid <= 1'b0;
    n = 0;
    while (filtered_pixels_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (filtered_pixels_q.size() != 0) begin
      $display("%0t %0d expected results never arrived, next pixel_out %0d",
               $time, filtered_pixels_q.size(), filtered_pixels_q[0].pix);
      mismatches++;
      filtered_pixels_q.delete();
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_WIDTH) begin
      cfg_width = dim_t'(value);
    end else begin
      cfg_height = dim_t'(value);
    end
    restart_counters();
  endtask

  task automatic write_dims(input int unsigned w, input int unsigned h, input bit junk);
    apb_write(REG_WIDTH, {junk ? 21'($urandom) : 21'd0, 11'(w)});
    apb_write(REG_HEIGHT, {junk ? 21'($urandom) : 21'd0, 11'(h)});
  endtask

  function automatic pix_t pick_pixel(pix_mix_t mix);
    case (mix)
      MIX_EXTREME: begin
        return $urandom_range(1) ? 8'hFF : 8'h00;
      end
      MIX_LEVELS: begin
        return pix_t'($urandom_range(3) * 85);
      end
      MIX_NARROW: begin
        return pix_t'($urandom_range(140, 120));
      end
      default: begin
        return pix_t'($urandom);
      end
    endcase
  endfunction

  // Noise: stray drains among the pixels, excess pixels among the drains.
  task automatic stream_frame(input int unsigned npix, input int unsigned ndrain,
                              input pix_mix_t mix, input int noise);
    int unsigned i;
    for (i = 0; i < npix; i++) begin
      if ($urandom_range(99) < noise) begin
        send_item(OP_DRAIN, pix_t'($urandom));
      end
      send_item(OP_PIXEL, pick_pixel(mix));
    end
    for (i = 0; i < ndrain; i++) begin
      if ($urandom_range(99) < noise) begin
        send_item(OP_PIXEL, pick_pixel(mix));
      end else begin
        send_item(OP_DRAIN, pix_t'($urandom));
      end
    end
  endtask

  function automatic int unsigned frame_px();
    return usable_dim(cfg_width, MAX_WIDTH) * usable_dim(cfg_height, MAX_HEIGHT);
  endfunction

  function automatic int unsigned frame_drains();
    return usable_dim(cfg_width, MAX_WIDTH) + 1;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_size();
    stream_frame(645, 0, MIX_UNIFORM, 0);
    wait_drained();
  endtask

  task automatic test_special_items();
    pix_t px[9] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h00};
    int   i;
    write_dims(3, 3, 1'b0);
    send_item(OP_DRAIN, 8'hFF);
    for (i = 0; i < 9; i++) begin
      send_item(OP_PIXEL, px[i]);
      if (i == 4) begin
        send_item(OP_DRAIN, 8'h3C);
      end
    end
    send_item(OP_DRAIN, 8'h00);
    send_item(OP_PIXEL, 8'hC3);
    send_item(OP_DRAIN, 8'hFF);
    send_item(OP_DRAIN, 8'h00);
    wait_drained();
  endtask

  task automatic test_size_extremes();
    int unsigned ws[9] = '{0, 1, 2, 2047, 1, 2, 9, 5, 3};
    int unsigned hs[9] = '{0, 1, 2, 1, 2047, 9, 2, 3, 3};
    int          k;
    for (k = 0; k < 9; k++) begin
      write_dims(ws[k], hs[k], k[0]);
      if (ws[k] > MAX_WIDTH) begin
        stream_frame(frame_drains() + 5, 0, pix_mix_t'(k % 4), 0);
      end else begin
        stream_frame(frame_px(), frame_drains(), pix_mix_t'(k % 4), 0);
      end
      wait_drained();
    end
  endtask

  task automatic test_pause_midframe();
    write_dims(6, 6, 1'b0);
    stream_frame(20, 0, MIX_UNIFORM, 0);
    wait_drained();
    stream_frame(16, 7, MIX_UNIFORM, 0);
    wait_drained();
  endtask

  task automatic test_truncated_frame();
    write_dims(8, 5, 1'b0);
    stream_frame(17, 0, MIX_EXTREME, 0);
    wait_drained();
    apb_write(REG_HEIGHT, 32'd4);
    stream_frame(frame_px(), frame_drains(), MIX_LEVELS, 0);
    wait_drained();
  endtask

  task automatic test_random_frames();
    int          start;
    int unsigned w;
    int unsigned h;
    int unsigned r;
    bit          need_cfg;
    pix_mix_t    mix;
    start    = items_fed;
    need_cfg = 1'b1;
    while (items_fed - start < RANDOM_ITEMS) begin
      send_gaps_on   = !(items_fed - start >= 100 && items_fed - start < 200);
      recv_stalls_on = send_gaps_on;
      if (need_cfg || $urandom_range(99) < 60) begin
        r = $urandom_range(99);
        if (r < 70) begin
          w = $urandom_range(12, 1);
          h = $urandom_range(8, 1);
        end else if (r < 88) begin
          w = $urandom_range(40, 3);
          h = $urandom_range(6, 3);
        end else begin
          w = $urandom_range(3, 0);
          h = $urandom_range(3, 0);
        end
        wait_drained();
        write_dims(w, h, $urandom_range(3) == 0);
        need_cfg = 1'b0;
      end
      mix = pix_mix_t'($urandom_range(3));
      if ($urandom_range(99) < 6) begin
        stream_frame($urandom_range(frame_px() - 1, 0), 0, mix, 3);
        need_cfg = 1'b1;
      end else begin
        stream_frame(frame_px(), frame_drains(), mix, 3);
      end
    end
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < HIST_LEN; i++) begin
      hist_px[i] = '0;
    end
    cfg_width  = dim_t'(RESET_WIDTH);
    cfg_height = dim_t'(RESET_HEIGHT);
    restart_counters();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_size();
    test_special_items();
    test_size_extremes();
    test_pause_midframe();
    test_truncated_frame();
    test_random_frames();
    wait_drained();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
